[rtl/core/llepd_pkg.sv]
// llepd_pkg: shared types and constants for the login line editor with ppp detect
// used by llepd_echo_seq and login_line_editor_ppp_detect_core
// no dependencies
`default_nettype none

package llepd_pkg;

   // line storage geometry
   localparam int LINE_SLOTS  = 32;
   localparam int IDX_W       = $clog2(LINE_SLOTS);
   localparam int KILL_BLANKS = 37;
   localparam int MAX_RESULTS = KILL_BLANKS + 3;
   localparam int STEP_W      = $clog2(MAX_RESULTS);

   // input operations
   typedef enum logic [1:0] {
      OP_RX    = 2'd0,
      OP_READ  = 2'd1,
      OP_START = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // line status codes
   localparam logic [2:0] ST_EDIT = 3'd0;
   localparam logic [2:0] ST_NAME = 3'd1;
   localparam logic [2:0] ST_PPP  = 3'd2;
   localparam logic [2:0] ST_NUL  = 3'd3;
   localparam logic [2:0] ST_EOF  = 3'd4;

   // configuration register indexes
   localparam logic [2:0] CSR_PPP_EN  = 3'd0;
   localparam logic [2:0] CSR_ERASE   = 3'd1;
   localparam logic [2:0] CSR_KILL    = 3'd2;
   localparam logic [2:0] CSR_EOF     = 3'd3;
   localparam logic [2:0] CSR_IGN_CTL = 3'd4;
   localparam logic [2:0] CSR_FAST    = 3'd5;
   localparam logic [2:0] CSR_PARITY  = 3'd6;

   // parity modes, anything else passes the byte through
   localparam logic [1:0] PARITY_EVEN = 2'd0;
   localparam logic [1:0] PARITY_ODD  = 2'd1;

   // characters
   localparam logic [6:0] CH_BS    = 7'h08;
   localparam logic [6:0] CH_LF    = 7'h0a;
   localparam logic [6:0] CH_CR    = 7'h0d;
   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_HASH  = 7'h23;
   localparam logic [6:0] CH_AT    = 7'h40;
   localparam logic [6:0] CH_DEL   = 7'h7f;

   // echo sequences that one word can cause
   typedef enum logic [2:0] {
      ECHO_NONE,
      ECHO_BYTE,
      ECHO_CRLF,
      ECHO_ERASE,
      ECHO_KILL_SLOW,
      ECHO_KILL_SHORT,
      ECHO_KILL_LONG
   } echo_kind_type;

   // everything the response side needs about one accepted word
   typedef struct packed {
      echo_kind_type    kind;
      logic [7:0]       rx_byte;
      logic [2:0]       status;
      logic             prompt;
      logic [3:0]       flags;
      logic [IDX_W-1:0] length;
      logic             read_hit;
   } desc_type;

endpackage

`default_nettype wire

[rtl/core/llepd_echo_seq.sv]
// llepd_echo_seq: response stage, walks the echo sequence of one word and applies parity
// depends on llepd_pkg
`default_nettype none

module llepd_echo_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load_valid,
   input  wire llepd_pkg::desc_type  load_desc,
   input  wire logic [6:0]           load_rd_data,
   input  wire logic [1:0]           parity_mode,
   output logic                      load_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_echo_valid,
   output logic [7:0]                rsp_echo_byte,
   output logic                      rsp_last,
   output logic [2:0]                rsp_status,
   output logic                      rsp_prompt_request,
   output logic                      rsp_saw_lower,
   output logic                      rsp_saw_upper,
   output logic                      rsp_saw_digit,
   output logic                      rsp_ended_with_cr,
   output logic [4:0]                rsp_line_length,
   output logic [6:0]                rsp_read_char
);

   logic                            valid_ff, valid_in;
   llepd_pkg::desc_type             desc_ff, desc_in;
   logic [6:0]                      rchar_ff, rchar_in;
   logic [llepd_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [llepd_pkg::STEP_W-1:0]    last_step;
   logic                            advance;
   logic                            at_last;
   logic [7:0]                      raw_byte;
   logic                            par_bit;

   // index of the final word of the current sequence
   always_comb begin
      case (desc_ff.kind)
         llepd_pkg::ECHO_CRLF:       last_step = llepd_pkg::STEP_W'(1);
         llepd_pkg::ECHO_ERASE:      last_step = llepd_pkg::STEP_W'(2);
         llepd_pkg::ECHO_KILL_SLOW:  last_step = llepd_pkg::STEP_W'(2);
         llepd_pkg::ECHO_KILL_SHORT: last_step = llepd_pkg::STEP_W'(1);
         llepd_pkg::ECHO_KILL_LONG:  last_step = llepd_pkg::STEP_W'(llepd_pkg::MAX_RESULTS - 1);
         default:                    last_step = '0;
      endcase
   end

   assign at_last    = (step_ff == last_step);
   assign advance    = valid_ff && !rsp_stall;
   assign load_ready = !valid_ff || (advance && at_last);

   // next sequence state
   always_comb begin
      valid_in = valid_ff;
      desc_in  = desc_ff;
      rchar_in = rchar_ff;
      step_in  = step_ff;
      if (load_ready) begin
         valid_in = load_valid;
         desc_in  = load_desc;
         rchar_in = load_desc.read_hit ? load_rd_data : 7'd0;
         step_in  = '0;
      end else if (advance) begin
         step_in = step_ff + llepd_pkg::STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff  <= desc_in;
      rchar_ff <= rchar_in;
      step_ff  <= step_in;
   end

   // byte of the sequence at this step, before parity
   always_comb begin
      raw_byte = 8'd0;
      case (desc_ff.kind)
         llepd_pkg::ECHO_BYTE: begin
            raw_byte = desc_ff.rx_byte;
         end
         llepd_pkg::ECHO_CRLF: begin
            raw_byte = {1'b0, (step_ff == '0) ? llepd_pkg::CH_CR : llepd_pkg::CH_LF};
         end
         llepd_pkg::ECHO_ERASE: begin
            raw_byte = {1'b0, (step_ff == llepd_pkg::STEP_W'(1)) ? llepd_pkg::CH_SPACE
                                                                 : llepd_pkg::CH_BS};
         end
         llepd_pkg::ECHO_KILL_SLOW, llepd_pkg::ECHO_KILL_SHORT: begin
            if (step_ff == '0) begin
               raw_byte = desc_ff.rx_byte;
            end else if (step_ff == llepd_pkg::STEP_W'(1)) begin
               raw_byte = {1'b0, llepd_pkg::CH_CR};
            end else begin
               raw_byte = {1'b0, llepd_pkg::CH_LF};
            end
         end
         llepd_pkg::ECHO_KILL_LONG: begin
            if (step_ff == '0) begin
               raw_byte = desc_ff.rx_byte;
            end else if (step_ff == llepd_pkg::STEP_W'(1) || at_last) begin
               raw_byte = {1'b0, llepd_pkg::CH_CR};
            end else begin
               raw_byte = {1'b0, llepd_pkg::CH_SPACE};
            end
         end
         default: begin
            raw_byte = 8'd0;
         end
      endcase
   end

   // parity goes into bit 7, or-ed over the received bit
   assign par_bit = ^raw_byte[6:0];

   always_comb begin
      rsp_echo_byte = raw_byte;
      if (desc_ff.kind != llepd_pkg::ECHO_NONE) begin
         if (parity_mode == llepd_pkg::PARITY_EVEN) begin
            rsp_echo_byte[7] = raw_byte[7] | par_bit;
         end else if (parity_mode == llepd_pkg::PARITY_ODD) begin
            rsp_echo_byte[7] = ~(raw_byte[7] | par_bit);
         end
      end
   end

   // fields of the current word; all but rsp_last are shared by every word of the item
   assign rsp_valid          = valid_ff;
   assign rsp_echo_valid     = (desc_ff.kind != llepd_pkg::ECHO_NONE);
   assign rsp_last           = at_last;
   assign rsp_status         = desc_ff.status;
   assign rsp_prompt_request = desc_ff.prompt;
   assign rsp_saw_lower      = desc_ff.flags[0];
   assign rsp_saw_upper      = desc_ff.flags[1];
   assign rsp_saw_digit      = desc_ff.flags[2];
   assign rsp_ended_with_cr  = desc_ff.flags[3];
   assign rsp_line_length    = 5'(desc_ff.length);
   assign rsp_read_char      = rchar_ff;

endmodule

`default_nettype wire

[rtl/core/login_line_editor_ppp_detect_core.sv]
// login_line_editor_ppp_detect_core: top level, byte decode, ppp detector and line memory
// depends on llepd_pkg and llepd_echo_seq
//
// usage:
//   req channel (req_valid / req_stall) carries one word per operation: a received
//   byte, a read of a stored line entry, or a start of a new line.
//   rsp channel (rsp_valid / rsp_stall) returns one word per echoed byte, or a single
//   word without echo; rsp_last marks the final word of an item.
//   csr_we writes register csr_index with csr_wdata; do this only while idle.
// path: an accepted request passes the pending stage, then the sequencer register.
// throughput: one request per cycle while each gives a single word and rsp_stall
//   is low; an item with n echo words holds the response side for all n words
//   (a kill on a fast line with text gives 40), one word per cycle unless stalled.
// the line is kept in a 32 x 7 memory with a registered read; a read request
//   samples the memory at acceptance, so every earlier write is already in place.
// stall: a pending stage sits between decode and the response sequencer, so one
//   more request is taken while a response waits; beyond that req_stall rises.
// reset: registers return to defaults, line empty, status editing; the line
//   memory is not cleared and needs no sweep.
`default_nettype none

module login_line_editor_ppp_detect_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [6:0]  csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic [4:0]  req_read_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_echo_valid,
   output logic [7:0]       rsp_echo_byte,
   output logic             rsp_last,
   output logic [2:0]       rsp_status,
   output logic             rsp_prompt_request,
   output logic             rsp_saw_lower,
   output logic             rsp_saw_upper,
   output logic             rsp_saw_digit,
   output logic             rsp_ended_with_cr,
   output logic [4:0]       rsp_line_length,
   output logic [6:0]       rsp_read_char
);

   // configuration registers
   logic        ppp_en_ff;
   logic [6:0]  erase_ff;
   logic [6:0]  kill_ff;
   logic [6:0]  eof_ff;
   logic        ign_ctl_ff;
   logic        fast_ff;
   logic [1:0]  parity_ff;

   // line state
   logic [2:0]                 phase_ff, phase_in;
   logic [llepd_pkg::IDX_W-1:0] count_ff, count_in;
   logic [3:0]                 flags_ff, flags_in;
   logic [2:0]                 status_ff, status_in;

   // line memory
   logic [6:0]                  line_mem [llepd_pkg::LINE_SLOTS];
   logic [6:0]                  rd_data_ff;
   logic [llepd_pkg::IDX_W-1:0] rd_addr;
   logic                        wr_en;

   // pending stage
   logic                pend_valid_ff, pend_valid_in;
   llepd_pkg::desc_type pend_ff;
   llepd_pkg::desc_type desc_new;

   logic                  req_acc;
   logic                  seq_ready;
   logic                  pend_move;
   llepd_pkg::echo_kind_type kind;
   logic                  prompt;
   logic                  read_hit;
   logic                  keep_char;
   logic [6:0]            ch;
   logic [2:0]            ppp_next;
   logic                  ppp_match;
   logic                  is_lower, is_upper, is_digit, is_erase, is_kill, is_ctrl;

   assign req_acc   = req_valid && !req_stall;
   assign pend_move = pend_valid_ff && seq_ready;
   assign req_stall = pend_valid_ff && !seq_ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ppp_en_ff  <= 1'b1;
         erase_ff   <= 7'd127;
         kill_ff    <= 7'd21;
         eof_ff     <= 7'd4;
         ign_ctl_ff <= 1'b0;
         fast_ff    <= 1'b1;
         parity_ff  <= llepd_pkg::PARITY_EVEN;
      end else if (csr_we) begin
         unique case (csr_index)
            llepd_pkg::CSR_PPP_EN:  ppp_en_ff  <= csr_wdata[0];
            llepd_pkg::CSR_ERASE:   erase_ff   <= csr_wdata;
            llepd_pkg::CSR_KILL:    kill_ff    <= csr_wdata;
            llepd_pkg::CSR_EOF:     eof_ff     <= csr_wdata;
            llepd_pkg::CSR_IGN_CTL: ign_ctl_ff <= csr_wdata[0];
            llepd_pkg::CSR_FAST:    fast_ff    <= csr_wdata[0];
            llepd_pkg::CSR_PARITY:  parity_ff  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // character classes
   assign ch       = req_rx_byte[6:0];
   assign is_lower = (ch >= 7'h61) && (ch <= 7'h7a);
   assign is_upper = (ch >= 7'h41) && (ch <= 7'h5a);
   assign is_digit = (ch >= 7'h30) && (ch <= 7'h39);
   assign is_erase = (ch == erase_ff) || (ch == llepd_pkg::CH_HASH) || (ch == llepd_pkg::CH_BS);
   assign is_kill  = (ch == kill_ff) || (ch == llepd_pkg::CH_AT);
   assign is_ctrl  = (ch <= llepd_pkg::CH_SPACE) || (ch == llepd_pkg::CH_DEL);

   // ppp frame start detector: 7e ff (7d 23 | 03) c0 21
   always_comb begin
      ppp_match = 1'b0;
      if (ppp_en_ff && req_rx_byte == 8'h7e) begin
         ppp_next = 3'd1;
      end else if (phase_ff == 3'd1 && req_rx_byte == 8'hff) begin
         ppp_next = 3'd2;
      end else if (phase_ff == 3'd2 && req_rx_byte == 8'h7d) begin
         ppp_next = 3'd3;
      end else if ((phase_ff == 3'd2 && req_rx_byte == 8'h03) ||
                   (phase_ff == 3'd3 && req_rx_byte == 8'h23)) begin
         ppp_next = 3'd4;
      end else if (phase_ff == 3'd4 && req_rx_byte == 8'hc0) begin
         ppp_next = 3'd5;
      end else if (phase_ff == 3'd5 && req_rx_byte == 8'h21) begin
         ppp_next  = 3'd0;
         ppp_match = 1'b1;
      end else begin
         ppp_next = 3'd0;
      end
   end

   // decode one request against the line state
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      flags_in  = flags_ff;
      status_in = status_ff;
      kind      = llepd_pkg::ECHO_NONE;
      prompt    = 1'b0;
      read_hit  = 1'b0;
      wr_en     = 1'b0;
      keep_char = 1'b0;
      unique case (llepd_pkg::op_type'(req_op))
         llepd_pkg::OP_START: begin
            phase_in  = 3'd0;
            count_in  = '0;
            flags_in  = 4'd0;
            status_in = llepd_pkg::ST_EDIT;
         end
         llepd_pkg::OP_READ: begin
            read_hit = (32'(req_read_index) < 32'(count_ff));
         end
         llepd_pkg::OP_RX: begin
            if (status_ff == llepd_pkg::ST_EDIT) begin
               if (ch == 7'd0) begin
                  status_in = llepd_pkg::ST_NUL;
               end else begin
                  phase_in = ppp_next;
                  if (ppp_match) begin
                     status_in = llepd_pkg::ST_PPP;
                  end else if (ch == eof_ff) begin
                     status_in = llepd_pkg::ST_EOF;
                  end else if (ch == llepd_pkg::CH_CR || ch == llepd_pkg::CH_LF ||
                               32'(count_ff) >= llepd_pkg::LINE_SLOTS - 1) begin
                     kind      = llepd_pkg::ECHO_CRLF;
                     status_in = llepd_pkg::ST_NAME;
                     if (ch == llepd_pkg::CH_CR) begin
                        flags_in[3] = 1'b1;
                     end
                  end else if (is_lower) begin
                     flags_in[0] = 1'b1;
                     keep_char   = 1'b1;
                  end else if (is_upper) begin
                     flags_in[1] = 1'b1;
                     keep_char   = 1'b1;
                  end else if (is_erase) begin
                     if (count_ff != '0) begin
                        count_in = count_ff - llepd_pkg::IDX_W'(1);
                        kind     = fast_ff ? llepd_pkg::ECHO_ERASE : llepd_pkg::ECHO_BYTE;
                     end
                  end else if (is_kill) begin
                     prompt   = 1'b1;
                     count_in = '0;
                     if (!fast_ff) begin
                        kind = llepd_pkg::ECHO_KILL_SLOW;
                     end else if (count_ff != '0) begin
                        kind = llepd_pkg::ECHO_KILL_LONG;
                     end else begin
                        kind = llepd_pkg::ECHO_KILL_SHORT;
                     end
                  end else begin
                     if (is_digit) begin
                        flags_in[2] = 1'b1;
                     end
                     keep_char = 1'b1;
                  end
                  // store and echo unless dropped as control
                  if (keep_char && !(ign_ctl_ff && is_ctrl)) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + llepd_pkg::IDX_W'(1);
                     kind     = llepd_pkg::ECHO_BYTE;
                  end
               end
            end
         end
         llepd_pkg::OP_NONE: begin
         end
      endcase
   end

   // line state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 3'd0;
         count_ff  <= '0;
         flags_ff  <= 4'd0;
         status_ff <= llepd_pkg::ST_EDIT;
      end else if (req_acc) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         flags_ff  <= flags_in;
         status_ff <= status_in;
      end
   end

   // line memory, one write and one registered read port
   assign rd_addr = llepd_pkg::IDX_W'(req_read_index);

   always_ff @(posedge clock) begin
      if (req_acc && wr_en) begin
         line_mem[count_ff] <= ch;
      end
      if (req_acc) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   // descriptor of the accepted word
   always_comb begin
      desc_new.kind     = kind;
      desc_new.rx_byte  = req_rx_byte;
      desc_new.status   = status_in;
      desc_new.prompt   = prompt;
      desc_new.flags    = flags_in;
      desc_new.length   = count_in;
      desc_new.read_hit = read_hit;
   end

   // pending stage between decode and response sequencer
   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (req_acc) begin
         pend_valid_in = 1'b1;
      end else if (pend_move) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         pend_ff <= desc_new;
      end
   end

   // response sequencer
   llepd_echo_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .load_valid         (pend_valid_ff),
      .load_desc          (pend_ff),
      .load_rd_data       (rd_data_ff),
      .parity_mode        (parity_ff),
      .load_ready         (seq_ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_echo_valid     (rsp_echo_valid),
      .rsp_echo_byte      (rsp_echo_byte),
      .rsp_last           (rsp_last),
      .rsp_status         (rsp_status),
      .rsp_prompt_request (rsp_prompt_request),
      .rsp_saw_lower      (rsp_saw_lower),
      .rsp_saw_upper      (rsp_saw_upper),
      .rsp_saw_digit      (rsp_saw_digit),
      .rsp_ended_with_cr  (rsp_ended_with_cr),
      .rsp_line_length    (rsp_line_length),
      .rsp_read_char      (rsp_read_char)
   );

endmodule

`default_nettype wire

[test/login_line_editor_ppp_detect_core_test.sv]
`timescale 1ns / 1ps
// login_line_editor_ppp_detect_core_test: self-checking bench for the login line editor
// drives request words, predicts every response word and compares them field by field
// depends on llepd_pkg and login_line_editor_ppp_detect_core

module login_line_editor_ppp_detect_core_test;

   localparam int RANDOM_ITEMS = 130;
   localparam int PHASE_ITEMS  = 30;

   // register index that maps to nothing
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   // ppp frame start bytes
   localparam logic [7:0] PPP_FLAG     = 8'h7e;
   localparam logic [7:0] PPP_ADDR     = 8'hff;
   localparam logic [7:0] PPP_ESC      = 8'h7d;
   localparam logic [7:0] PPP_CTRL_ESC = 8'h23;
   localparam logic [7:0] PPP_CTRL     = 8'h03;
   localparam logic [7:0] PPP_PROTO_HI = 8'hc0;
   localparam logic [7:0] PPP_PROTO_LO = 8'h21;

   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_byte;
      logic       last;
      logic [2:0] status;
      logic       prompt;
      logic       lower;
      logic       upper;
      logic       digit;
      logic       cr;
      logic [4:0] length;
      logic [6:0] read_char;
   } rsp_word_type;

   // bench driven signals
   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       csr_we         = 1'b0;
   logic [2:0] csr_index      = 3'd0;
   logic [6:0] csr_wdata      = 7'd0;
   logic       req_valid      = 1'b0;
   logic [1:0] req_op         = 2'd0;
   logic [7:0] req_rx_byte    = 8'd0;
   logic [4:0] req_read_index = 5'd0;
   logic       rsp_stall      = 1'b0;

   // block outputs
   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_echo_valid;
   logic [7:0] rsp_echo_byte;
   logic       rsp_last;
   logic [2:0] rsp_status;
   logic       rsp_prompt_request;
   logic       rsp_saw_lower;
   logic       rsp_saw_upper;
   logic       rsp_saw_digit;
   logic       rsp_ended_with_cr;
   logic [4:0] rsp_line_length;
   logic [6:0] rsp_read_char;

   // register copies, reset values
   logic       cfg_ppp_en = 1'b1;
   logic [6:0] cfg_erase  = 7'd127;
   logic [6:0] cfg_kill   = 7'd21;
   logic [6:0] cfg_eof    = 7'd4;
   logic       cfg_ignore = 1'b0;
   logic       cfg_fast   = 1'b1;
   logic [1:0] cfg_parity = 2'd0;

   // predicted editor state
   int            ppp_phase_m = 0;
   logic [6:0]    line_mem [llepd_pkg::LINE_SLOTS];
   int            line_len    = 0;
   logic [3:0]    line_flags  = 4'd0;
   logic [2:0]    line_st     = llepd_pkg::ST_EDIT;
   logic [7:0]    echo_out [$];
   rsp_word_type  due_words [$];

   // run control and tallies
   bit gaps_on       = 1'b1;
   bit stall_on      = 1'b1;
   int stall_left    = 0;
   int error_count   = 0;
   int items_sent    = 0;
   int useful_items  = 0;
   int words_checked = 0;
   int kill_count    = 0;
   int ppp_count     = 0;
   int setting_count = 0;

   always #4 clock = ~clock;

   login_line_editor_ppp_detect_core dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_rx_byte        (req_rx_byte),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_echo_valid     (rsp_echo_valid),
      .rsp_echo_byte      (rsp_echo_byte),
      .rsp_last           (rsp_last),
      .rsp_status         (rsp_status),
      .rsp_prompt_request (rsp_prompt_request),
      .rsp_saw_lower      (rsp_saw_lower),
      .rsp_saw_upper      (rsp_saw_upper),
      .rsp_saw_digit      (rsp_saw_digit),
      .rsp_ended_with_cr  (rsp_ended_with_cr),
      .rsp_line_length    (rsp_line_length),
      .rsp_read_char      (rsp_read_char)
   );

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // echo byte with the parity bit ored into bit 7
   function automatic void add_echo(input logic [7:0] b);
      logic [7:0] c;
      c = b;
      if (cfg_parity == llepd_pkg::PARITY_EVEN || cfg_parity == llepd_pkg::PARITY_ODD) begin
         c[7] = b[7] | (^b[6:0]);
         if (cfg_parity == llepd_pkg::PARITY_ODD) c[7] = ~c[7];
      end
      echo_out.push_back(c);
   endfunction

   // one received byte while editing, returns 1 when the line was killed
   function automatic bit take_rx(input logic [7:0] b);
      logic [6:0] c;
      bit         ppp_hit;
      c = b[6:0];
      ppp_hit = 1'b0;
      if (c == 7'h00) begin
         line_st = llepd_pkg::ST_NUL;
         return 1'b0;
      end
      // frame start detector runs on the full byte
      if (cfg_ppp_en && b == PPP_FLAG) ppp_phase_m = 1;
      else if (ppp_phase_m == 1 && b == PPP_ADDR) ppp_phase_m = 2;
      else if (ppp_phase_m == 2 && b == PPP_ESC) ppp_phase_m = 3;
      else if ((ppp_phase_m == 2 && b == PPP_CTRL) || (ppp_phase_m == 3 && b == PPP_CTRL_ESC))
         ppp_phase_m = 4;
      else if (ppp_phase_m == 4 && b == PPP_PROTO_HI) ppp_phase_m = 5;
      else if (ppp_phase_m == 5 && b == PPP_PROTO_LO) begin
         ppp_phase_m = 0;
         ppp_hit = 1'b1;
      end else ppp_phase_m = 0;
      if (ppp_hit) begin
         line_st = llepd_pkg::ST_PPP;
         return 1'b0;
      end
      if (c == cfg_eof) begin
         line_st = llepd_pkg::ST_EOF;
         return 1'b0;
      end
      // line end by cr, lf or a full line
      if (c == llepd_pkg::CH_CR || c == llepd_pkg::CH_LF ||
          line_len >= llepd_pkg::LINE_SLOTS - 1) begin
         add_echo({1'b0, llepd_pkg::CH_CR});
         add_echo({1'b0, llepd_pkg::CH_LF});
         line_st = llepd_pkg::ST_NAME;
         if (c == llepd_pkg::CH_CR) line_flags[3] = 1'b1;
         return 1'b0;
      end
      // letters win over erase and kill
      if (c >= "a" && c <= "z") begin
         line_flags[0] = 1'b1;
      end else if (c >= "A" && c <= "Z") begin
         line_flags[1] = 1'b1;
      end else if (c == cfg_erase || c == llepd_pkg::CH_HASH || c == llepd_pkg::CH_BS) begin
         if (line_len > 0) begin
            line_len--;
            if (cfg_fast) begin
               add_echo({1'b0, llepd_pkg::CH_BS});
               add_echo({1'b0, llepd_pkg::CH_SPACE});
               add_echo({1'b0, llepd_pkg::CH_BS});
            end else begin
               add_echo(b);
            end
         end
         return 1'b0;
      end else if (c == cfg_kill || c == llepd_pkg::CH_AT) begin
         add_echo(b);
         add_echo({1'b0, llepd_pkg::CH_CR});
         if (!cfg_fast) begin
            add_echo({1'b0, llepd_pkg::CH_LF});
         end else if (line_len > 0) begin
            repeat (llepd_pkg::KILL_BLANKS) add_echo({1'b0, llepd_pkg::CH_SPACE});
            add_echo({1'b0, llepd_pkg::CH_CR});
         end
         line_len = 0;
         return 1'b1;
      end else if (c >= "0" && c <= "9") begin
         line_flags[2] = 1'b1;
      end
      // dropped control characters still set no flag and give no echo
      if (cfg_ignore && (c <= llepd_pkg::CH_SPACE || c == llepd_pkg::CH_DEL)) return 1'b0;
      line_mem[line_len] = c;
      line_len++;
      add_echo(b);
      return 1'b0;
   endfunction

   // expected response words of one accepted request word
   task automatic predict_edit(input llepd_pkg::op_type op, input logic [7:0] b,
                               input logic [4:0] idx);
      logic [6:0]   rd;
      logic [2:0]   old_st;
      bit           prq;
      int           n;
      rsp_word_type w;
      rd = 7'd0;
      prq = 1'b0;
      old_st = line_st;
      echo_out.delete();
      case (op)
         llepd_pkg::OP_START: begin
            ppp_phase_m = 0;
            line_len = 0;
            line_flags = 4'd0;
            line_st = llepd_pkg::ST_EDIT;
         end
         llepd_pkg::OP_READ: begin
            if (idx < line_len) rd = line_mem[idx];
         end
         llepd_pkg::OP_RX: begin
            if (line_st == llepd_pkg::ST_EDIT) prq = take_rx(b);
         end
         default: ;
      endcase
      if (prq) kill_count++;
      if (old_st == llepd_pkg::ST_EDIT && line_st == llepd_pkg::ST_PPP) ppp_count++;
      n = (echo_out.size() != 0) ? echo_out.size() : 1;
      for (int k = 0; k < n; k++) begin
         w.echo_valid = (echo_out.size() != 0);
         w.echo_byte  = w.echo_valid ? echo_out[k] : 8'h00;
         w.last       = (k == n - 1);
         w.status     = line_st;
         w.prompt     = prq;
         w.lower      = line_flags[0];
         w.upper      = line_flags[1];
         w.digit      = line_flags[2];
         w.cr         = line_flags[3];
         w.length     = line_len[4:0];
         w.read_char  = rd;
         due_words.push_back(w);
      end
   endtask

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("%0t: response word %0d, %s: got %0h want %0h",
               $time, words_checked, what, got, want);
   endtask

   task automatic compare_field(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // compare each accepted response word with the oldest prediction
   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (due_words.size() == 0) begin
            report_mismatch("word with nothing expected", 32'(rsp_echo_byte), 32'd0);
         end else begin
            want = due_words.pop_front();
            compare_field("echo_valid", 32'(rsp_echo_valid), 32'(want.echo_valid));
            compare_field("echo_byte", 32'(rsp_echo_byte), 32'(want.echo_byte));
            compare_field("last", 32'(rsp_last), 32'(want.last));
            compare_field("status", 32'(rsp_status), 32'(want.status));
            compare_field("prompt_request", 32'(rsp_prompt_request), 32'(want.prompt));
            compare_field("saw_lower", 32'(rsp_saw_lower), 32'(want.lower));
            compare_field("saw_upper", 32'(rsp_saw_upper), 32'(want.upper));
            compare_field("saw_digit", 32'(rsp_saw_digit), 32'(want.digit));
            compare_field("ended_with_cr", 32'(rsp_ended_with_cr), 32'(want.cr));
            compare_field("line_length", 32'(rsp_line_length), 32'(want.length));
            compare_field("read_char", 32'(rsp_read_char), 32'(want.read_char));
            words_checked++;
         end
      end
   end

   // receiver stalls in bursts of random length
   always @(posedge clock) begin
      if (!stall_on) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // driving
   // ------------------------------------------------------------------

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [4:0] rand_index();
      return 5'($urandom_range(0, 31));
   endfunction

   function automatic logic hi_bit();
      return ($urandom_range(0, 3) == 0);
   endfunction

   // letter or digit, now and then with bit 7 set
   function automatic logic [7:0] pick_name_char();
      logic [6:0] c;
      case ($urandom_range(0, 2))
         0: c = 7'(7'h61 + $urandom_range(0, 25));
         1: c = 7'(7'h41 + $urandom_range(0, 25));
         default: c = 7'(7'h30 + $urandom_range(0, 9));
      endcase
      return {($urandom_range(0, 7) == 0), c};
   endfunction

   // one request word, with an optional idle burst before it
   task automatic send_word(input llepd_pkg::op_type op, input logic [7:0] b,
                            input logic [4:0] idx);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         req_op <= 2'($urandom_range(0, 3));
         req_rx_byte <= rand_byte();
         req_read_index <= rand_index();
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_rx_byte <= b;
      req_read_index <= idx;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (!(op == llepd_pkg::OP_RX && line_st != llepd_pkg::ST_EDIT)) useful_items++;
      items_sent++;
      predict_edit(op, b, idx);
   endtask

   // hold the sender until every predicted word has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_words.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_put(input logic [2:0] idx, input logic [6:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // write every register from the bench copies, junk above narrow fields
   task automatic load_config(input bit junk);
      logic [6:0] j;
      j = junk ? 7'($urandom_range(0, 127)) : 7'd0;
      csr_put(llepd_pkg::CSR_PPP_EN, {j[6:1], cfg_ppp_en});
      csr_put(llepd_pkg::CSR_ERASE, cfg_erase);
      csr_put(llepd_pkg::CSR_KILL, cfg_kill);
      csr_put(llepd_pkg::CSR_EOF, cfg_eof);
      csr_put(llepd_pkg::CSR_IGN_CTL, {j[6:1], cfg_ignore});
      csr_put(llepd_pkg::CSR_FAST, {j[6:1], cfg_fast});
      csr_put(llepd_pkg::CSR_PARITY, {j[6:2], cfg_parity});
      if (junk) csr_put(CSR_UNUSED, j);
      csr_we <= 1'b0;
      @(posedge clock);
      setting_count++;
   endtask

   function automatic logic [6:0] pick_char_reg();
      case ($urandom_range(0, 3))
         0: return 7'd0;
         1: return 7'd127;
         default: return 7'($urandom_range(0, 127));
      endcase
   endfunction

   // eof mostly kept off common text so lines get some length
   function automatic logic [6:0] pick_eof_reg();
      case ($urandom_range(0, 3))
         0: return 7'd0;
         1: return 7'd127;
         2: return 7'($urandom_range(1, 31));
         default: return 7'($urandom_range(0, 127));
      endcase
   endfunction

   // one login attempt: start word, edit words, maybe bytes after the end
   task automatic run_session();
      int         len;
      int         kind;
      int         k;
      logic [7:0] frame [$];
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 36) : $urandom_range(2, 14);
      send_word(llepd_pkg::OP_START, rand_byte(), rand_index());
      for (k = 0; k < len && line_st == llepd_pkg::ST_EDIT; k++) begin
         if (gaps_on && $urandom_range(0, 19) == 0) wait_idle();
         // long names are plain name characters only so the line fills up
         kind = (len >= 30) ? $urandom_range(0, 44) : $urandom_range(0, 99);
         if (kind < 45) begin
            send_word(llepd_pkg::OP_RX, pick_name_char(), rand_index());
         end else if (kind < 53) begin
            case ($urandom_range(0, 2))
               0: send_word(llepd_pkg::OP_RX, {hi_bit(), llepd_pkg::CH_HASH}, rand_index());
               1: send_word(llepd_pkg::OP_RX, {hi_bit(), llepd_pkg::CH_BS}, rand_index());
               default: send_word(llepd_pkg::OP_RX, {hi_bit(), cfg_erase}, rand_index());
            endcase
         end else if (kind < 58) begin
            if ($urandom_range(0, 1) == 0)
               send_word(llepd_pkg::OP_RX, {hi_bit(), llepd_pkg::CH_AT}, rand_index());
            else send_word(llepd_pkg::OP_RX, {hi_bit(), cfg_kill}, rand_index());
         end else if (kind < 66) begin
            if ($urandom_range(0, 1) == 0)
               send_word(llepd_pkg::OP_READ, rand_byte(), rand_index());
            else send_word(llepd_pkg::OP_READ, rand_byte(), 5'($urandom_range(0, line_len)));
         end else if (kind < 78) begin
            send_word(llepd_pkg::OP_RX, rand_byte(), rand_index());
         end else if (kind < 83) begin
            // ppp frame start, sometimes with one byte spoiled
            frame.delete();
            frame.push_back(PPP_FLAG);
            frame.push_back(PPP_ADDR);
            if ($urandom_range(0, 1) == 0) begin
               frame.push_back(PPP_ESC);
               frame.push_back(PPP_CTRL_ESC);
            end else begin
               frame.push_back(PPP_CTRL);
            end
            frame.push_back(PPP_PROTO_HI);
            frame.push_back(PPP_PROTO_LO);
            if ($urandom_range(0, 3) == 0) frame[$urandom_range(0, frame.size() - 1)] = rand_byte();
            foreach (frame[i])
               if (line_st == llepd_pkg::ST_EDIT)
                  send_word(llepd_pkg::OP_RX, frame[i], rand_index());
         end else if (kind < 88) begin
            if ($urandom_range(0, 1) == 0)
               send_word(llepd_pkg::OP_RX, {hi_bit(), llepd_pkg::CH_CR}, rand_index());
            else send_word(llepd_pkg::OP_RX, {hi_bit(), llepd_pkg::CH_LF}, rand_index());
         end else if (kind < 91) begin
            send_word(llepd_pkg::OP_RX, {hi_bit(), cfg_eof}, rand_index());
         end else if (kind < 93) begin
            send_word(llepd_pkg::OP_RX, {hi_bit(), 7'h00}, rand_index());
         end else begin
            send_word(llepd_pkg::OP_NONE, rand_byte(), rand_index());
         end
      end
      // words after the end of the line
      if ($urandom_range(0, 2) == 0) begin
         send_word(llepd_pkg::OP_RX, rand_byte(), rand_index());
         send_word(llepd_pkg::OP_READ, rand_byte(), rand_index());
      end
   endtask

   // register setting for one random phase, extremes first
   task automatic new_setting(input int phase_no);
      case (phase_no)
         0: begin
            cfg_ppp_en = 1'b0; cfg_erase = 7'd0; cfg_kill = 7'd0; cfg_eof = 7'd0;
            cfg_ignore = 1'b0; cfg_fast = 1'b0; cfg_parity = 2'd0;
         end
         1: begin
            cfg_ppp_en = 1'b1; cfg_erase = 7'd127; cfg_kill = 7'd127; cfg_eof = 7'd127;
            cfg_ignore = 1'b1; cfg_fast = 1'b1; cfg_parity = 2'd3;
         end
         default: begin
            cfg_ppp_en = ($urandom_range(0, 3) != 0);
            cfg_erase  = pick_char_reg();
            cfg_kill   = pick_char_reg();
            cfg_eof    = pick_eof_reg();
            cfg_ignore = 1'($urandom_range(0, 1));
            cfg_fast   = 1'($urandom_range(0, 1));
            cfg_parity = 2'($urandom_range(0, 3));
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // plain editing at reset settings, reads, unused op, bytes after the end
   task automatic test_basic_editing();
      send_word(llepd_pkg::OP_START, 8'h00, 5'd0);
      send_word(llepd_pkg::OP_RX, "a", 5'd31);
      send_word(llepd_pkg::OP_RX, "Z", 5'd0);
      send_word(llepd_pkg::OP_RX, "5", 5'd0);
      send_word(llepd_pkg::OP_RX, {1'b0, llepd_pkg::CH_BS}, 5'd0);
      send_word(llepd_pkg::OP_READ, 8'hff, 5'd0);
      send_word(llepd_pkg::OP_READ, 8'h00, 5'd31);
      send_word(llepd_pkg::OP_RX, 8'he1, 5'd0);
      send_word(llepd_pkg::OP_NONE, 8'h55, 5'd3);
      send_word(llepd_pkg::OP_RX, {1'b0, llepd_pkg::CH_CR}, 5'd0);
      send_word(llepd_pkg::OP_RX, "x", 5'd0);
      send_word(llepd_pkg::OP_READ, 8'h00, 5'd1);
   endtask

   // erase on an empty line, long kill, short kills
   task automatic test_erase_kill();
      send_word(llepd_pkg::OP_START, 8'h00, 5'd0);
      send_word(llepd_pkg::OP_RX, {1'b0, llepd_pkg::CH_HASH}, 5'd0);
      send_word(llepd_pkg::OP_RX, "k", 5'd0);
      send_word(llepd_pkg::OP_RX, {1'b0, llepd_pkg::CH_AT}, 5'd0);
      send_word(llepd_pkg::OP_RX, {1'b1, llepd_pkg::CH_AT}, 5'd0);
      send_word(llepd_pkg::OP_RX, {1'b0, cfg_kill}, 5'd0);
   endtask

   task automatic test_ppp_call();
      send_word(llepd_pkg::OP_START, 8'h00, 5'd0);
      send_word(llepd_pkg::OP_RX, PPP_FLAG, 5'd0);
      send_word(llepd_pkg::OP_RX, PPP_ADDR, 5'd0);
      send_word(llepd_pkg::OP_RX, PPP_CTRL, 5'd0);
      send_word(llepd_pkg::OP_RX, PPP_PROTO_HI, 5'd0);
      send_word(llepd_pkg::OP_RX, PPP_PROTO_LO, 5'd0);
   endtask

   // nul with bit 7 set aborts, eof character ends
   task automatic test_abort_eof();
      send_word(llepd_pkg::OP_START, 8'h00, 5'd0);
      send_word(llepd_pkg::OP_RX, "q", 5'd0);
      send_word(llepd_pkg::OP_RX, 8'h80, 5'd0);
      send_word(llepd_pkg::OP_START, 8'h00, 5'd0);
      send_word(llepd_pkg::OP_RX, {1'b0, cfg_eof}, 5'd0);
   endtask

   // slow line, odd parity, dropped controls, a letter as erase character (stored as a letter) and digit kill
   task automatic test_slow_line();
      wait_idle();
      cfg_ppp_en = 1'b0; cfg_erase = 7'("e"); cfg_kill = 7'("7"); cfg_eof = llepd_pkg::CH_DEL;
      cfg_ignore = 1'b1; cfg_fast = 1'b0; cfg_parity = llepd_pkg::PARITY_ODD;
      load_config(1'b1);
      send_word(llepd_pkg::OP_START, 8'h00, 5'd0);
      send_word(llepd_pkg::OP_RX, "e", 5'd0);
      send_word(llepd_pkg::OP_RX, {1'b0, llepd_pkg::CH_SPACE}, 5'd0);
      send_word(llepd_pkg::OP_RX, "b", 5'd0);
      send_word(llepd_pkg::OP_RX, {1'b0, llepd_pkg::CH_BS}, 5'd0);
      send_word(llepd_pkg::OP_RX, "7", 5'd0);
      send_word(llepd_pkg::OP_RX, PPP_FLAG, 5'd0);
      send_word(llepd_pkg::OP_RX, {1'b1, llepd_pkg::CH_DEL}, 5'd0);
   endtask

   // fill 31 of the 32 slots, the next byte ends the line
   task automatic test_full_line();
      wait_idle();
      cfg_ppp_en = 1'b1; cfg_erase = llepd_pkg::CH_DEL; cfg_kill = 7'd21; cfg_eof = 7'd4;
      cfg_ignore = 1'b0; cfg_fast = 1'b1; cfg_parity = 2'd2;
      load_config(1'b0);
      send_word(llepd_pkg::OP_START, rand_byte(), rand_index());
      repeat (llepd_pkg::LINE_SLOTS - 1)
         send_word(llepd_pkg::OP_RX, pick_name_char(), rand_index());
      send_word(llepd_pkg::OP_READ, rand_byte(), 5'(llepd_pkg::LINE_SLOTS - 2));
      send_word(llepd_pkg::OP_RX, {1'b0, llepd_pkg::CH_HASH}, rand_index());
   endtask

   // sender waits for the receiver to drain before every word after the start word
   task automatic test_sender_pause();
      send_word(llepd_pkg::OP_START, rand_byte(), rand_index());
      repeat (8) begin
         wait_idle();
         send_word(llepd_pkg::OP_RX,
                   ($urandom_range(0, 3) == 0) ? {1'b0, llepd_pkg::CH_AT} : pick_name_char(),
                   rand_index());
      end
   endtask

   task automatic test_random_sessions();
      int base;
      int phase_base;
      int phase_no;
      base = useful_items;
      phase_base = useful_items;
      phase_no = 0;
      wait_idle();
      new_setting(phase_no);
      load_config(1'b0);
      while (useful_items - base < RANDOM_ITEMS) begin
         if (useful_items - phase_base >= PHASE_ITEMS) begin
            wait_idle();
            phase_no++;
            new_setting(phase_no);
            load_config(1'($urandom_range(0, 1)));
            gaps_on = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            phase_base = useful_items;
         end
         run_session();
      end
   endtask

   // closing stretch without any idling
   task automatic test_quiet_finish();
      gaps_on = 1'b0;
      stall_on = 1'b0;
      repeat (3) run_session();
   endtask

   // ------------------------------------------------------------------
   // sequence and end of run
   // ------------------------------------------------------------------

   initial begin : main_flow
      int drain;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      load_config(1'b0);
      test_basic_editing();
      test_erase_kill();
      test_ppp_call();
      test_abort_eof();
      test_slow_line();
      test_full_line();
      test_sender_pause();
      test_random_sessions();
      test_quiet_finish();
      req_valid <= 1'b0;
      drain = 0;
      while (due_words.size() != 0 && drain < 100000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (due_words.size() != 0)
         report_mismatch("words never received", due_words.size(), 32'd0);
      $display("covered %0d request words with %0d line kills and %0d ppp calls",
               items_sent, kill_count, ppp_count);
      $display("checked %0d response words over %0d register settings",
               words_checked, setting_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/llepd_pkg.sv
rtl/core/llepd_echo_seq.sv
rtl/core/login_line_editor_ppp_detect_core.sv
test/login_line_editor_ppp_detect_core_test.sv
